>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers that are clocked on clk and disabled during
// reset. They expand to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("assertion failed");
// When ante holds, cons must hold at the same edge.
`define ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// When ante holds, cons must hold at the next edge.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, cond)
`define ASSERT_IMPLIES(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> hw/rtl/mcw_pkg.sv
// ----------------------------------------------------------------------------
// mcw_pkg
// Shared types and constants of the minimum covering window search.
// ----------------------------------------------------------------------------
package mcw_pkg;

	// Fixed field widths.
	localparam int CHAR_W     = 8;
	localparam int WIN_W      = 10;
	localparam int SLOTS_ALL  = 8;
	localparam int PAT_W      = CHAR_W * SLOTS_ALL;
	localparam int LEN_W      = 4;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = PAT_W;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_CHARS  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 1'b1;

	// Reset value of the pattern length register.
	localparam logic [LEN_W-1:0] PATTERN_LENGTH_RESET = 4'd1;

	// One text byte.
	typedef struct packed {
		logic [CHAR_W-1:0] text_byte;
		logic              last_byte;
	} in_t;

	// One search result.
	typedef struct packed {
		logic             found;
		logic [WIN_W-1:0] window_start;
		logic [WIN_W-1:0] window_end;
		logic             too_long;
	} out_t;

endpackage

>>> hw/rtl/mcw_slot_match.sv
// ----------------------------------------------------------------------------
// mcw_slot_match
// Works out which pattern slots are required, which of them the current byte
// hits, whether every required slot has now been seen, and where the window
// that ends at the current byte starts.
// ----------------------------------------------------------------------------
module mcw_slot_match
	import mcw_pkg::*;
#(
	parameter int SLOTS = 8,
	parameter int PW    = 10
) (
	input  logic [PAT_W-1:0]  pattern_chars,
	input  logic [LEN_W-1:0]  pattern_length,
	input  logic [CHAR_W-1:0] text_byte,
	input  logic [PW-1:0]     pos,
	input  logic [PW-1:0]     last_seen [SLOTS],
	input  logic [SLOTS-1:0]  seen,
	output logic [SLOTS-1:0]  hit,
	output logic              covered,
	output logic [PW-1:0]     start
);

	logic [LEN_W-1:0] len_eff;
	logic [SLOTS-1:0] dup;
	logic [SLOTS-1:0] req;
	logic [SLOTS-1:0] seen_next;

	// Clamp the pattern length to the range of slots that exist.
	always_comb begin
		if (pattern_length == '0) begin
			len_eff = 4'd1;
		end else if (pattern_length > LEN_W'(SLOTS)) begin
			len_eff = LEN_W'(SLOTS);
		end else begin
			len_eff = pattern_length;
		end
	end

	// A slot that repeats the byte of an earlier slot is not required.
	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			dup[i] = 1'b0;
			for (int k = 0; k < i; k++) begin
				if (pattern_chars[CHAR_W*k +: CHAR_W] == pattern_chars[CHAR_W*i +: CHAR_W]) begin
					dup[i] = 1'b1;
				end
			end
			req[i] = (LEN_W'(i) < len_eff) && !dup[i];
			hit[i] = req[i] && (pattern_chars[CHAR_W*i +: CHAR_W] == text_byte);
		end
	end

	assign seen_next = seen | hit;
	assign covered   = (req != '0) && ((seen_next & req) == req);

	// Slots hit now move to the current position, so only the others can
	// pull the start of the window back.
	always_comb begin
		start = pos;
		for (int i = 0; i < SLOTS; i++) begin
			if (req[i] && !hit[i] && (last_seen[i] < start)) begin
				start = last_seen[i];
			end
		end
	end

endmodule

>>> hw/rtl/minimum_covering_window.sv
// ----------------------------------------------------------------------------
// minimum_covering_window
// Streaming search for the shortest window of text that holds every
// character of a configured pattern.
// ----------------------------------------------------------------------------
// The block takes one text byte per cycle, with no gaps needed between
// transfers: a byte is registered on transfer and then fully processed in
// the input stage by one pass of slot compares and an eight-way minimum, so
// the input stays ready as long as the result register is free or being
// drained. The result for a text is registered when its last byte leaves
// the input stage and waits in the output register while the next text
// already streams in; the input stalls only when a second last byte meets an
// unread result. Positions count from zero, the earliest of equally short
// windows wins, and a text longer than MAX_TEXT bytes reports too_long with
// found clear. Pattern bytes that repeat an earlier byte count once. All
// state lives in flip-flops and is ready straight after reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module minimum_covering_window
	import mcw_pkg::*;
#(
	parameter int MAX_TEXT    = 1024,
	parameter int MAX_PATTERN = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_t                   in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_t                  out_data
);

	// Position widths: stored positions stay below MAX_TEXT, the counter
	// saturates at MAX_TEXT itself.
	localparam int PW = (MAX_TEXT > 2) ? $clog2(MAX_TEXT) : 1;
	localparam int CW = $clog2(MAX_TEXT + 1);
	localparam logic [CW-1:0] POS_LIMIT = CW'(MAX_TEXT);

	// Configuration registers.
	logic [PAT_W-1:0] pattern_chars_q;
	logic [LEN_W-1:0] pattern_length_q;

	// Input stage.
	logic              valid_s1;
	logic [CHAR_W-1:0] byte_s1;
	logic              last_s1;
	logic              adv_s1;

	// Search state.
	logic [CW-1:0]          pos_q;
	logic [PW-1:0]          last_seen_q [MAX_PATTERN];
	logic [MAX_PATTERN-1:0] seen_q;
	logic [PW-1:0]          best_start_q;
	logic [PW-1:0]          best_end_q;
	logic                   best_valid_q;
	logic                   ovf_q;

	// Next-state values.
	logic [PW-1:0]          cur_pos;
	logic                   in_range;
	logic [MAX_PATTERN-1:0] hit;
	logic                   covered;
	logic [PW-1:0]          start;
	logic                   better;
	logic [PW-1:0]          best_start_d;
	logic [PW-1:0]          best_end_d;
	logic                   best_valid_d;
	logic                   ovf_d;
	logic [PW+WIN_W-1:0]    start_ext;
	logic [PW+WIN_W-1:0]    end_ext;

	// Result register.
	logic out_valid_q;
	out_t out_data_q;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_chars_q  <= '0;
			pattern_length_q <= PATTERN_LENGTH_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_PATTERN_CHARS:  pattern_chars_q  <= cfg_data;
				REG_PATTERN_LENGTH: pattern_length_q <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// The input stage moves on unless it holds a last byte and the result
	// register is still full.
	assign adv_s1   = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_data.text_byte;
			last_s1 <= in_data.last_byte;
		end
	end

	// Slot compares and window start for the byte in the input stage.
	assign cur_pos  = pos_q[PW-1:0];
	assign in_range = (pos_q < POS_LIMIT);

	mcw_slot_match #(
		.SLOTS(MAX_PATTERN),
		.PW   (PW)
	) u_slot_match (
		.pattern_chars (pattern_chars_q),
		.pattern_length(pattern_length_q),
		.text_byte     (byte_s1),
		.pos           (cur_pos),
		.last_seen     (last_seen_q),
		.seen          (seen_q),
		.hit           (hit),
		.covered       (covered),
		.start         (start)
	);

	// Keep the new window only when it is strictly shorter than the best.
	assign better = in_range && covered &&
		(!best_valid_q || ((cur_pos - start) < (best_end_q - best_start_q)));

	assign best_start_d = better ? start   : best_start_q;
	assign best_end_d   = better ? cur_pos : best_end_q;
	assign best_valid_d = best_valid_q || better;
	assign ovf_d        = ovf_q || !in_range;

	// Search state update; a last byte clears the state after its result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			seen_q       <= '0;
			best_start_q <= '0;
			best_end_q   <= '0;
			best_valid_q <= 1'b0;
			ovf_q        <= 1'b0;
			for (int i = 0; i < MAX_PATTERN; i++) begin
				last_seen_q[i] <= '0;
			end
		end else if (adv_s1) begin
			if (last_s1) begin
				pos_q        <= '0;
				seen_q       <= '0;
				best_start_q <= '0;
				best_end_q   <= '0;
				best_valid_q <= 1'b0;
				ovf_q        <= 1'b0;
				for (int i = 0; i < MAX_PATTERN; i++) begin
					last_seen_q[i] <= '0;
				end
			end else begin
				best_start_q <= best_start_d;
				best_end_q   <= best_end_d;
				best_valid_q <= best_valid_d;
				ovf_q        <= ovf_d;
				if (in_range) begin
					pos_q  <= pos_q + 1'b1;
					seen_q <= seen_q | hit;
					for (int i = 0; i < MAX_PATTERN; i++) begin
						if (hit[i]) begin
							last_seen_q[i] <= cur_pos;
						end
					end
				end
			end
		end
	end

	// Result fields carry the low bits of the positions.
	assign start_ext = {{WIN_W{1'b0}}, best_start_d};
	assign end_ext   = {{WIN_W{1'b0}}, best_end_d};

	// Result register: loaded on a last byte, emptied by a transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			if (ovf_d) begin
				out_data_q.found        <= 1'b0;
				out_data_q.window_start <= '0;
				out_data_q.window_end   <= '0;
				out_data_q.too_long     <= 1'b1;
			end else if (best_valid_d) begin
				out_data_q.found        <= 1'b1;
				out_data_q.window_start <= start_ext[WIN_W-1:0];
				out_data_q.window_end   <= end_ext[WIN_W-1:0];
				out_data_q.too_long     <= 1'b0;
			end else begin
				out_data_q.found        <= 1'b0;
				out_data_q.window_start <= '0;
				out_data_q.window_end   <= '0;
				out_data_q.too_long     <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// A last byte that leaves the input stage always yields a result.
	`ASSERT_NEXT(a_result_after_last, adv_s1 && last_s1, out_valid_q)
	// The input stage only holds when a finished result has not been taken.
	`ASSERT_IMPLIES(a_stall_cause, valid_s1 && !adv_s1, out_valid_q && !out_ready)
	// An overflow is only flagged once the position counter has saturated.
	`ASSERT_IMPLIES(a_ovf_saturated, ovf_q, pos_q == POS_LIMIT)
	// The best window never runs backwards.
	`ASSERT_IMPLIES(a_best_ordered, best_valid_q, best_start_q <= best_end_q)
	// A result never claims both a window and an overflow.
	`ASSERT_IMPLIES(a_result_flags, out_valid_q, !(out_data_q.found && out_data_q.too_long))

endmodule
